// ----- rtl/hbsmr_pkg.sv -----
// ----------------------------------------------------------------------------
// hbsmr_pkg
// Shared types and constants of the bit-serial message receiver.
// ----------------------------------------------------------------------------
package hbsmr_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;
  localparam int unsigned ID_W            = 22;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned ACK_W           = 2;
  localparam int unsigned BIT_CNT_W       = 4;

  localparam logic [BIT_CNT_W-1:0] BYTE_BITS = BIT_CNT_W'(BYTE_W);

  localparam logic [ACK_W-1:0] ACK_NONE   = 2'd0;
  localparam logic [ACK_W-1:0] ACK_SINGLE = 2'd1;
  localparam logic [ACK_W-1:0] ACK_DOUBLE = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_LENGTH  = 2'd2,
    PH_DATA    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [ACK_W-1:0]  ack_count;
    logic [ID_W-1:0]   ack_target;
    logic              connected;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_value;
    logic              message_done;
  } result_t;

endpackage

// ----- rtl/handshake_bit_serial_message_receiver.sv -----
// ----------------------------------------------------------------------------
// handshake_bit_serial_message_receiver
// Binds a peer, takes a length and data bytes one bit per event, acknowledges.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    sender_id, bit_value
//   out      out  out_valid/out_stall  ack_count, ack_target, connected,
//                                      byte_valid, byte_value, message_done
//
// One event per clock while the output is not stalled; each result shows up in the cycle after its transfer.
// Latency and rate are set by the single result register after the link logic.
// rst (synchronous) returns to idle with no peer bound and an empty output.
// A stalled result holds the input channel stalled in the same cycle; a
// result that is taken frees the slot for a new transfer in that cycle.
// ----------------------------------------------------------------------------
module handshake_bit_serial_message_receiver #(
  parameter int unsigned LENGTH_BITS = hbsmr_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hbsmr_pkg::ID_W-1:0]     sender_id,
  input  logic                           bit_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hbsmr_pkg::ACK_W-1:0]    ack_count,
  output logic [hbsmr_pkg::ID_W-1:0]     ack_target,
  output logic                           connected,
  output logic                           byte_valid,
  output logic [hbsmr_pkg::BYTE_W-1:0]   byte_value,
  output logic                           message_done
);
  import hbsmr_pkg::*;

  logic    take;
  result_t res_comb;
  result_t res_reg;

  hbsmr_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .sender_id (sender_id),
    .bit_value (bit_value),
    .res       (res_comb)
  );

  hbsmr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .take      (take),
    .res_in    (res_comb),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_reg)
  );

  assign ack_count    = res_reg.ack_count;
  assign ack_target   = res_reg.ack_target;
  assign connected    = res_reg.connected;
  assign byte_valid   = res_reg.byte_valid;
  assign byte_value   = res_reg.byte_value;
  assign message_done = res_reg.message_done;

endmodule

// ----- rtl/hbsmr_core.sv -----
// ----------------------------------------------------------------------------
// hbsmr_core
// Link state, length and byte shifters; forms the result of one bit event.
// ----------------------------------------------------------------------------
module hbsmr_core #(
  parameter int unsigned LENGTH_BITS = hbsmr_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [hbsmr_pkg::ID_W-1:0]   sender_id,
  input  logic                         bit_value,
  output hbsmr_pkg::result_t           res
);
  import hbsmr_pkg::*;

  localparam int unsigned LCW = (LENGTH_BITS > 1) ? $clog2(LENGTH_BITS) : 1;
  localparam logic [LCW-1:0] LEN_LAST = LCW'(LENGTH_BITS - 1);

  phase_t                 phase, phase_next;
  logic [ID_W-1:0]        peer_id, peer_id_next;
  logic [LENGTH_BITS-1:0] message_length, message_length_next;
  logic [LCW-1:0]         length_bits_seen, length_bits_seen_next;
  logic [BIT_CNT_W-1:0]   byte_bits_seen, byte_bits_seen_next;
  logic [LENGTH_BITS-1:0] bytes_received, bytes_received_next;
  logic [BYTE_W-1:0]      byte_shift, byte_shift_next;

  logic                   from_peer;
  logic                   byte_ready;
  logic                   len_last;
  logic [LENGTH_BITS-1:0] bytes_after;
  logic                   more_bytes;
  logic                   at_end;
  logic [BYTE_W-1:0]      shift_base;
  logic [BIT_CNT_W-1:0]   bits_base;

  assign from_peer   = (sender_id == peer_id);
  assign byte_ready  = (phase == PH_DATA) && (byte_bits_seen == BYTE_BITS);
  assign len_last    = (length_bits_seen == LEN_LAST);
  // a finished byte counts before the length compare of the same event
  assign bytes_after = bytes_received + LENGTH_BITS'(byte_ready);
  assign more_bytes  = (bytes_after < message_length);
  assign at_end      = (bytes_after == message_length);
  assign shift_base  = byte_ready ? '0 : byte_shift;
  assign bits_base   = byte_ready ? '0 : byte_bits_seen;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (!bit_value) phase_next = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (!bit_value && from_peer) phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (from_peer && len_last) phase_next = PH_DATA;
      end
      PH_DATA: begin
        if (from_peer && at_end) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    peer_id_next          = peer_id;
    message_length_next   = message_length;
    length_bits_seen_next = length_bits_seen;
    byte_bits_seen_next   = byte_bits_seen;
    bytes_received_next   = bytes_received;
    byte_shift_next       = byte_shift;
    res                   = '0;
    case (phase)
      PH_IDLE: begin
        if (!bit_value) begin
          peer_id_next   = sender_id;
          res.ack_count  = ACK_SINGLE;
          res.ack_target = sender_id;
          res.connected  = 1'b1;
        end
      end
      PH_CONFIRM: begin
        if (!bit_value && from_peer) begin
          res.ack_count  = ACK_SINGLE;
          res.ack_target = peer_id;
        end
      end
      PH_LENGTH: begin
        if (from_peer) begin
          message_length_next = {message_length[LENGTH_BITS-2:0], bit_value};
          res.ack_target      = peer_id;
          if (len_last) begin
            length_bits_seen_next = '0;
            res.ack_count         = ACK_DOUBLE;
          end else begin
            length_bits_seen_next = length_bits_seen + 1'b1;
            res.ack_count         = ACK_SINGLE;
          end
        end
      end
      PH_DATA: begin
        if (byte_ready) begin
          res.byte_valid      = 1'b1;
          res.byte_value      = byte_shift;
          byte_bits_seen_next = '0;
          byte_shift_next     = '0;
          bytes_received_next = bytes_after;
        end
        if (from_peer && more_bytes) begin
          byte_shift_next     = {shift_base[BYTE_W-2:0], bit_value};
          byte_bits_seen_next = bits_base + 1'b1;
          res.ack_count       = ACK_SINGLE;
          res.ack_target      = peer_id;
        end else if (from_peer && at_end) begin
          // drop the link and clear everything for the next message
          res.message_done      = 1'b1;
          peer_id_next          = '0;
          message_length_next   = '0;
          length_bits_seen_next = '0;
          byte_bits_seen_next   = '0;
          bytes_received_next   = '0;
          byte_shift_next       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      peer_id          <= '0;
      message_length   <= '0;
      length_bits_seen <= '0;
      byte_bits_seen   <= '0;
      bytes_received   <= '0;
      byte_shift       <= '0;
    end else if (take) begin
      phase            <= phase_next;
      peer_id          <= peer_id_next;
      message_length   <= message_length_next;
      length_bits_seen <= length_bits_seen_next;
      byte_bits_seen   <= byte_bits_seen_next;
      bytes_received   <= bytes_received_next;
      byte_shift       <= byte_shift_next;
    end
  end

  a_bind_peer: assert property (@(posedge clk) disable iff (rst)
    take && (phase == PH_IDLE) && !bit_value
      |=> (phase == PH_CONFIRM) && (peer_id == $past(sender_id)))
    else $error("idle zero bit did not bind the sender");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    take && res.message_done
      |=> (phase == PH_IDLE) && (peer_id == '0) && (bytes_received == '0))
    else $error("message end left state behind");

  a_byte_bits_range: assert property (@(posedge clk) disable iff (rst)
    byte_bits_seen <= BYTE_BITS)
    else $error("byte bit counter overran");

endmodule

// ----- rtl/hbsmr_out_reg.sv -----
// ----------------------------------------------------------------------------
// hbsmr_out_reg
// Result register; takes a new event whenever the slot is free or draining.
// ----------------------------------------------------------------------------
module hbsmr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               take,
  input  hbsmr_pkg::result_t res_in,
  output logic               out_valid,
  input  logic               out_stall,
  output hbsmr_pkg::result_t res_out
);
  import hbsmr_pkg::*;

  logic    valid;
  result_t data;

  assign in_stall  = valid && out_stall;
  assign take      = in_valid && !in_stall;
  assign out_valid = valid;
  assign res_out   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (!out_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data <= res_in;
    end
  end

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> valid && (data == $past(res_in)))
    else $error("accepted event did not reach the result register");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    valid && !out_stall && !take |=> !valid)
    else $error("result register kept a delivered result");

endmodule
